// ----- hw/rtl/tta_pkg.sv -----
// shared types and constants of the transaction table with aging
package tta_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int KEY_W      = 32;
    localparam int CLIENT_W   = 48;
    localparam int HITS_W     = 16;
    localparam int STAMP_W    = 32;
    localparam int LIFETIME_W = 17;
    localparam int SLOT_W     = 4;
    localparam int STATUS_W   = 3;

    localparam logic [LIFETIME_W-1:0] LIFETIME_RESET = LIFETIME_W'(60);
    localparam logic [HITS_W-1:0]     HITS_MAX       = '1;

    typedef enum logic
    {
        OP_ADD   = 1'b0,
        OP_PURGE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_MATCHED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_PURGED   = 3'd3,
        ST_DONE     = 3'd4
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed
    {
        logic [KEY_W-1:0]    key;
        logic [CLIENT_W-1:0] client;
        logic [HITS_W-1:0]   hits;
        logic [STAMP_W-1:0]  stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed
    {
        logic                valid;
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    id;
        logic [CLIENT_W-1:0] address;
        logic [HITS_W-1:0]   hits;
        logic                last;
    } res_t;

endpackage

// ----- hw/rtl/transaction_table_with_aging.sv -----
// top level of the transaction table with aging
//
// channel   direction  handshake                 payload
// request   in         start & !busy             operation, transaction_id,
//                                                client_address, now_seconds
// result    out        result_valid, one cycle   status, slot, entry_id,
//                                                entry_address, hit_count, last
// config    in         cfg_we                    cfg_wdata (lifetime_seconds)
//
// an add ends on a match or after the last word; a purge always scans the whole table
// the scan reads one table word per cycle through the single ram read port
// purged words leave one per cycle during the scan, the done word follows
// reset empties the table at once through per-slot valid flops, lifetime is 60
// results cannot be held off by the receiver
module transaction_table_with_aging
#(
    parameter int TABLE_DEPTH = tta_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              operation,
    input  logic [tta_pkg::KEY_W-1:0]         transaction_id,
    input  logic [tta_pkg::CLIENT_W-1:0]      client_address,
    input  logic [tta_pkg::STAMP_W-1:0]       now_seconds,
    input  logic                              cfg_we,
    input  logic [tta_pkg::LIFETIME_W-1:0]    cfg_wdata,
    output logic                              result_valid,
    output logic [tta_pkg::STATUS_W-1:0]      status,
    output logic [tta_pkg::SLOT_W-1:0]        slot,
    output logic [tta_pkg::KEY_W-1:0]         entry_id,
    output logic [tta_pkg::CLIENT_W-1:0]      entry_address,
    output logic [tta_pkg::HITS_W-1:0]        hit_count,
    output logic                              last
);

    import tta_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [LIFETIME_W-1:0] lifetime_reg;
    logic                  valid_reg;
    res_t                  res;
    res_t                  res_reg;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    entry_t                ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    entry_t                ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg <= LIFETIME_RESET;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                lifetime_reg <= cfg_wdata;
            end
            valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res;
    end

    tta_ram
    #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    )
    u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tta_scan
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    u_scan
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .transaction_id (transaction_id),
        .client_address (client_address),
        .now_seconds    (now_seconds),
        .lifetime       (lifetime_reg),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .res            (res)
    );

    assign result_valid  = valid_reg;
    assign status        = res_reg.status;
    assign slot          = res_reg.slot;
    assign entry_id      = res_reg.id;
    assign entry_address = res_reg.address;
    assign hit_count     = res_reg.hits;
    assign last          = res_reg.last;

endmodule

// ----- hw/rtl/tta_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
module tta_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/tta_scan.sv -----
// table scan engine: valid bits, lookup, insert, refresh and purge sequencing
module tta_scan
#(
    parameter int TABLE_DEPTH = tta_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                operation,
    input  logic [tta_pkg::KEY_W-1:0]           transaction_id,
    input  logic [tta_pkg::CLIENT_W-1:0]        client_address,
    input  logic [tta_pkg::STAMP_W-1:0]         now_seconds,
    input  logic [tta_pkg::LIFETIME_W-1:0]      lifetime,
    output logic                                ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]      ram_waddr,
    output tta_pkg::entry_t                     ram_wdata,
    output logic                                ram_re,
    output logic [$clog2(TABLE_DEPTH)-1:0]      ram_raddr,
    input  tta_pkg::entry_t                     ram_rdata,
    output tta_pkg::res_t                       res
);

    import tta_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [KEY_W-1:0]       id_reg, id_next;
    logic [CLIENT_W-1:0]    addr_reg, addr_next;
    logic [STAMP_W-1:0]     now_reg, now_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   issue_end_reg, issue_end_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_slot_reg, free_slot_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;

    logic                   cur_valid;
    logic                   free_now;
    logic [IDX_W-1:0]       slot_now;
    logic [STAMP_W-1:0]     age;
    logic [HITS_W-1:0]      hits_inc;

    assign busy      = (state_reg != S_IDLE);
    assign ram_raddr = idx_reg;
    assign cur_valid = valid_reg[cmp_idx_reg];
    assign free_now  = free_found_reg | ~cur_valid;
    assign slot_now  = free_found_reg ? free_slot_reg : cmp_idx_reg;
    assign age       = now_reg - ram_rdata.stamp;
    assign hits_inc  = (ram_rdata.hits == HITS_MAX) ? ram_rdata.hits
                                                    : ram_rdata.hits + HITS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_end_reg  <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_end_reg  <= issue_end_next;
            cmp_valid_reg  <= cmp_valid_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        id_reg        <= id_next;
        addr_reg      <= addr_next;
        now_reg       <= now_next;
        idx_reg       <= idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        free_slot_reg <= free_slot_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        addr_next       = addr_reg;
        now_next        = now_reg;
        idx_next        = idx_reg;
        issue_end_next  = issue_end_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        valid_next      = valid_reg;
        ram_re          = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = cmp_idx_reg;
        ram_wdata       = ram_rdata;
        res             = '0;
        res.status      = ST_MATCHED;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next         = op_t'(operation);
                    id_next         = transaction_id;
                    addr_next       = client_address;
                    now_next        = now_seconds;
                    idx_next        = '0;
                    issue_end_next  = 1'b0;
                    cmp_valid_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // read issue stage
                if (!issue_end_reg)
                begin
                    ram_re = 1'b1;
                    if (idx_reg == IDX_LAST)
                    begin
                        issue_end_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                cmp_valid_next = ~issue_end_reg;
                cmp_idx_next   = idx_reg;

                // compare stage on returned word
                if (cmp_valid_reg)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        if (cur_valid && ram_rdata.key == id_reg)
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = cmp_idx_reg;
                            ram_wdata       = ram_rdata;
                            ram_wdata.hits  = hits_inc;
                            ram_wdata.stamp = now_reg;
                            res.valid       = 1'b1;
                            res.status      = ST_MATCHED;
                            res.slot        = SLOT_W'(cmp_idx_reg);
                            res.id          = ram_rdata.key;
                            res.address     = ram_rdata.client;
                            res.hits        = hits_inc;
                            res.last        = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            if (!free_found_reg && !cur_valid)
                            begin
                                free_found_next = 1'b1;
                                free_slot_next  = cmp_idx_reg;
                            end
                            if (cmp_idx_reg == IDX_LAST)
                            begin
                                res.valid = 1'b1;
                                res.last  = 1'b1;
                                res.id    = id_reg;
                                res.address = addr_reg;
                                if (free_now)
                                begin
                                    ram_we               = 1'b1;
                                    ram_waddr            = slot_now;
                                    ram_wdata.key        = id_reg;
                                    ram_wdata.client     = addr_reg;
                                    ram_wdata.hits       = HITS_W'(1);
                                    ram_wdata.stamp      = now_reg;
                                    valid_next[slot_now] = 1'b1;
                                    res.status           = ST_INSERTED;
                                    res.slot             = SLOT_W'(slot_now);
                                    res.hits             = HITS_W'(1);
                                end
                                else
                                begin
                                    res.status = ST_FULL;
                                end
                                state_next = S_IDLE;
                            end
                        end
                    end
                    else
                    begin
                        if (cur_valid && age >= STAMP_W'(lifetime))
                        begin
                            valid_next[cmp_idx_reg] = 1'b0;
                            res.valid   = 1'b1;
                            res.status  = ST_PURGED;
                            res.slot    = SLOT_W'(cmp_idx_reg);
                            res.id      = ram_rdata.key;
                            res.address = ram_rdata.client;
                            res.hits    = ram_rdata.hits;
                        end
                        if (cmp_idx_reg == IDX_LAST)
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_DONE:
            begin
                res.valid  = 1'b1;
                res.status = ST_DONE;
                res.last   = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/tta_checker.sv -----
// port-level checks of the transaction table with aging, bound to the top level
module tta_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         result_valid,
    input logic [tta_pkg::STATUS_W-1:0] status,
    input logic [tta_pkg::SLOT_W-1:0]   slot,
    input logic                         last
);

    import tta_pkg::*;

    // words only come out of work in flight
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result word without work in flight");

    // the final word of an item frees the block
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("busy still high on final word");

    // only purged-entry words are non-final
    a_nonfinal_is_purge: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> status == ST_PURGED)
        else $error("non-final word that is not a purged entry");

    // full and done carry slot zero
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_FULL || status == ST_DONE) |-> slot == '0)
        else $error("full or done word with nonzero slot");

    // work begins only on a start
    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

endmodule

bind transaction_table_with_aging tta_checker u_tta_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .status       (status),
    .slot         (slot),
    .last         (last)
);

// ----- tb/testbench.sv -----
// testbench of the transaction table with aging: table predictor, scoreboard and stimulus
import tta_pkg::*;

class aging_table_scoreboard;
    typedef struct {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    id;
        logic [CLIENT_W-1:0] address;
        logic [HITS_W-1:0]   hits;
        logic                last;
    } result_word_t;

    bit                    used   [TABLE_DEPTH_DEF];
    logic [KEY_W-1:0]      key    [TABLE_DEPTH_DEF];
    logic [CLIENT_W-1:0]   client [TABLE_DEPTH_DEF];
    logic [HITS_W-1:0]     hits   [TABLE_DEPTH_DEF];
    logic [STAMP_W-1:0]    stamp  [TABLE_DEPTH_DEF];
    logic [LIFETIME_W-1:0] lifetime;
    result_word_t          pending_words[$];
    int                    errors;
    int                    requests;
    int                    checked;
    int                    aged_out;
    int                    full_reports;
    int                    saturated;

    function new();
        foreach (used[i])
            used[i] = 1'b0;
        lifetime = LIFETIME_RESET;
    endfunction

    function void push_word(status_t st, int sl, logic [KEY_W-1:0] id_v,
                            logic [CLIENT_W-1:0] addr_v, logic [HITS_W-1:0] hits_v,
                            logic last_v);
        result_word_t w;
        w.status  = st;
        w.slot    = SLOT_W'(sl);
        w.id      = id_v;
        w.address = addr_v;
        w.hits    = hits_v;
        w.last    = last_v;
        pending_words.push_back(w);
    endfunction

    // works out the result words of one accepted request word
    function void apply_request(op_t op, logic [KEY_W-1:0] id_v,
                                logic [CLIENT_W-1:0] addr_v, logic [STAMP_W-1:0] now_v);
        int                 free_slot;
        logic [STAMP_W-1:0] age;
        free_slot = -1;
        requests++;
        if (op == OP_ADD)
        begin
            for (int i = 0; i < TABLE_DEPTH_DEF; i++)
            begin
                if (used[i] && key[i] == id_v)
                begin
                    if (hits[i] != HITS_MAX)
                        hits[i] = hits[i] + 1'b1;
                    else
                        saturated++;
                    stamp[i] = now_v;
                    push_word(ST_MATCHED, i, key[i], client[i], hits[i], 1'b1);
                    return;
                end
                if (!used[i] && free_slot < 0)
                    free_slot = i;
            end
            if (free_slot < 0)
            begin
                full_reports++;
                push_word(ST_FULL, 0, id_v, addr_v, '0, 1'b1);
                return;
            end
            used[free_slot]   = 1'b1;
            key[free_slot]    = id_v;
            client[free_slot] = addr_v;
            hits[free_slot]   = HITS_W'(1);
            stamp[free_slot]  = now_v;
            push_word(ST_INSERTED, free_slot, id_v, addr_v, HITS_W'(1), 1'b1);
        end
        else
        begin
            for (int i = 0; i < TABLE_DEPTH_DEF; i++)
            begin
                age = now_v - stamp[i];
                if (used[i] && age >= STAMP_W'(lifetime))
                begin
                    used[i] = 1'b0;
                    aged_out++;
                    push_word(ST_PURGED, i, key[i], client[i], hits[i], 1'b0);
                end
            end
            push_word(ST_DONE, 0, '0, '0, '0, 1'b1);
        end
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            errors++;
            if (errors <= 60)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endfunction

    function void check_word(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl,
                             logic [KEY_W-1:0] id_v, logic [CLIENT_W-1:0] addr_v,
                             logic [HITS_W-1:0] hits_v, logic last_v);
        result_word_t w;
        if (pending_words.size() == 0)
        begin
            errors++;
            $display("%0t: result word with none expected, expected nothing, actual status %0d slot %0d id %h",
                     $time, st, sl, id_v);
            return;
        end
        w = pending_words.pop_front();
        checked++;
        compare_field("status", 64'(w.status), 64'(st));
        compare_field("slot", 64'(w.slot), 64'(sl));
        compare_field("entry_id", 64'(w.id), 64'(id_v));
        compare_field("entry_address", 64'(w.address), 64'(addr_v));
        compare_field("hit_count", 64'(w.hits), 64'(hits_v));
        compare_field("last", 64'(w.last), 64'(last_v));
    endfunction
endclass

module testbench;
    import tta_pkg::*;

    localparam int CYCLE_LIMIT  = 100_000;
    localparam int DRAIN_CYCLES = TABLE_DEPTH_DEF + 4;
    localparam int PHASES       = 5;
    localparam int PHASE_WORDS  = 18;
    localparam int POOL_SIZE    = 20;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  operation;
    logic [KEY_W-1:0]      transaction_id;
    logic [CLIENT_W-1:0]   client_address;
    logic [STAMP_W-1:0]    now_seconds;
    logic                  cfg_we;
    logic [LIFETIME_W-1:0] cfg_wdata;
    logic                  result_valid;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot;
    logic [KEY_W-1:0]      entry_id;
    logic [CLIENT_W-1:0]   entry_address;
    logic [HITS_W-1:0]     hit_count;
    logic                  last;

    aging_table_scoreboard sb;
    int                    cycles;
    int                    idle_pct;
    logic [STAMP_W-1:0]    clock_now;
    logic [KEY_W-1:0]      id_pool[POOL_SIZE];

    transaction_table_with_aging i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .transaction_id (transaction_id),
        .client_address (client_address),
        .now_seconds    (now_seconds),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .result_valid   (result_valid),
        .status         (status),
        .slot           (slot),
        .entry_id       (entry_id),
        .entry_address  (entry_address),
        .hit_count      (hit_count),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("transaction_table_with_aging test failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
            sb.check_word(status, slot, entry_id, entry_address, hit_count, last);
    end

    function automatic logic [CLIENT_W-1:0] random_address();
        return CLIENT_W'({$urandom(), $urandom()});
    endfunction

    task automatic send_word(op_t op, logic [KEY_W-1:0] key_v,
                             logic [CLIENT_W-1:0] addr_v, logic [STAMP_W-1:0] now_v);
        start          <= 1'b1;
        operation      <= op;
        transaction_id <= key_v;
        client_address <= addr_v;
        now_seconds    <= now_v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.apply_request(op, key_v, addr_v, now_v);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending_words.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_lifetime(logic [LIFETIME_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.lifetime = value;
    endtask

    task automatic random_phase(int lt);
        op_t              op;
        logic [KEY_W-1:0] key_v;
        logic [STAMP_W-1:0] step;
        for (int n = 0; n < PHASE_WORDS; n++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: step = $urandom_range(lt / 8 + 1, 0);
                6, 7:             step = STAMP_W'(lt - 1 + $urandom_range(2));
                8:                step = '0;
                default:          step = $urandom();
            endcase
            clock_now = clock_now + step;
            op = ($urandom_range(99) < 15) ? OP_PURGE : OP_ADD;
            if ($urandom_range(9) < 8)
                key_v = id_pool[$urandom_range(POOL_SIZE - 1)];
            else
                key_v = $urandom();
            send_word(op, key_v, random_address(), clock_now);
        end
    endtask

    initial
    begin
        int phase_lifetime[PHASES];
        int phase_idle[PHASES];
        sb = new();
        phase_lifetime = '{86400, 1, 131071, 0, 60};
        phase_idle     = '{0, 85, 29, 0, 85};
        idle_pct = 0;
        rst_n          <= 1'b0;
        start          <= 1'b0;
        operation      <= OP_ADD;
        transaction_id <= '0;
        client_address <= '0;
        now_seconds    <= '0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, stored address kept on a hit, purge across the time wrap
        send_word(OP_ADD, '0, '0, '0);
        send_word(OP_ADD, '1, '1, '1);
        send_word(OP_ADD, '0, CLIENT_W'(48'h1234_5678_9abc), STAMP_W'(5));
        send_word(OP_PURGE, '1, '1, STAMP_W'(64));
        send_word(OP_PURGE, '0, '0, STAMP_W'(65));
        send_word(OP_PURGE, 32'h5a5a_5a5a, random_address(), STAMP_W'(66));

        // fill the table, then a miss and a hit while full
        for (int i = 1; i <= TABLE_DEPTH_DEF; i++)
            send_word(OP_ADD, KEY_W'(i * 32'h1111_1111), random_address(), STAMP_W'(100));
        send_word(OP_ADD, 32'h0bad_f00d, random_address(), STAMP_W'(100));
        send_word(OP_ADD, 32'h3333_3333, random_address(), STAMP_W'(101));

        // lifetime zero frees every entry
        write_lifetime('0);
        send_word(OP_PURGE, '0, '0, STAMP_W'(101));

        // repeated hits on one key raise its count
        for (int n = 0; n < 4; n++)
            send_word(OP_ADD, 32'ha5a5_a5a5, random_address(), STAMP_W'(n));
        send_word(OP_PURGE, '0, '0, '1);

        foreach (id_pool[i])
            id_pool[i] = $urandom();
        id_pool[0] = '0;
        id_pool[1] = '1;
        clock_now = 32'hffff_ff00;
        for (int p = 0; p < PHASES; p++)
        begin
            if (phase_lifetime[p] == 0)
                phase_lifetime[p] = $urandom_range(300, 2);
            write_lifetime(LIFETIME_W'(phase_lifetime[p]));
            idle_pct = phase_idle[p];
            random_phase(phase_lifetime[p]);
        end
        drain();

        $display("%0d request words, %0d result words checked, %0d entries aged out, %0d full reports",
                 sb.requests, sb.checked, sb.aged_out, sb.full_reports);
        $display("lifetimes 0 through 131071 used across the time wrap, %0d hits at the count maximum",
                 sb.saturated);
        if (sb.errors == 0 && sb.pending_words.size() == 0)
            $display("transaction_table_with_aging test passed");
        else
            $display("transaction_table_with_aging test failed");
        $finish;
    end
endmodule
